// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file rmq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define RMQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rmq check failed");

// Checked on every rising edge, reset included.
`define RMQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rmq check failed");

`endif

// ===== hw/rtl/rmq_pkg.sv =====
package rmq_pkg;

   localparam int LANES = 3;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

   // Per-transaction control that travels beside the datapath.
   typedef struct packed {
      branch_type       branch;
      logic             degen;
      logic [LANES-1:0] neg;
   } ctl_type;

endpackage

// ===== hw/rtl/rmq_sqrt_cell.sv =====
// One digit of the square root: takes two radicand bits, yields one root bit.
module rmq_sqrt_cell #(
   parameter int SQW = 16,
   parameter int DW  = 51
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  rmq_pkg::ctl_type      in_ctl,
   input  logic [2*SQW-1:0]      in_v,
   input  logic [SQW-1:0]        in_q,
   input  logic [SQW+2:0]        in_r,
   input  logic [DW-1:0]         in_data,
   output logic                  out_valid,
   output rmq_pkg::ctl_type      out_ctl,
   output logic [2*SQW-1:0]      out_v,
   output logic [SQW-1:0]        out_q,
   output logic [SQW+2:0]        out_r,
   output logic [DW-1:0]         out_data
);
   localparam int VW  = 2 * SQW;
   localparam int RMW = SQW + 3;

   logic                 valid_ff;
   rmq_pkg::ctl_type     ctl_ff;
   logic [VW-1:0]        v_ff, v_in;
   logic [SQW-1:0]       q_ff, q_in;
   logic [RMW-1:0]       r_ff, r_in;
   logic [DW-1:0]        data_ff;
   logic [RMW-1:0]       rp;
   logic [RMW-1:0]       trial;
   logic                 ge;

   always_comb begin
      rp    = {in_r[RMW-3:0], in_v[VW-1 -: 2]};
      trial = {1'b0, in_q, 2'b01};
      ge    = (rp >= trial);
      r_in  = ge ? (rp - trial) : rp;
      q_in  = {in_q[SQW-2:0], ge};
      v_in  = {in_v[VW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff  <= in_ctl;
         v_ff    <= v_in;
         q_ff    <= q_in;
         r_ff    <= r_in;
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_v     = v_ff;
   assign out_q     = q_ff;
   assign out_r     = r_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/rmq_div_cell.sv =====
// One quotient bit of restoring division, for all three lanes at once.
module rmq_div_cell #(
   parameter int NW  = 32,
   parameter int DVW = 18,
   parameter int LW  = 17
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  rmq_pkg::ctl_type                    in_ctl,
   input  logic [DVW-1:0]                      in_dvs,
   input  logic [LW-1:0]                       in_lead,
   input  logic [rmq_pkg::LANES-1:0][NW-1:0]   in_n,
   input  logic [rmq_pkg::LANES-1:0][DVW-1:0]  in_p,
   input  logic [rmq_pkg::LANES-1:0][NW-1:0]   in_q,
   output logic                                out_valid,
   output rmq_pkg::ctl_type                    out_ctl,
   output logic [DVW-1:0]                      out_dvs,
   output logic [LW-1:0]                       out_lead,
   output logic [rmq_pkg::LANES-1:0][NW-1:0]   out_n,
   output logic [rmq_pkg::LANES-1:0][DVW-1:0]  out_p,
   output logic [rmq_pkg::LANES-1:0][NW-1:0]   out_q
);
   localparam int PW = DVW + 1;

   logic                                valid_ff;
   rmq_pkg::ctl_type                    ctl_ff;
   logic [DVW-1:0]                      dvs_ff;
   logic [LW-1:0]                       lead_ff;
   logic [rmq_pkg::LANES-1:0][NW-1:0]   n_ff, n_in;
   logic [rmq_pkg::LANES-1:0][DVW-1:0]  p_ff, p_in;
   logic [rmq_pkg::LANES-1:0][NW-1:0]   q_ff, q_in;
   logic [rmq_pkg::LANES-1:0][PW-1:0]   ps;
   logic [PW-1:0]                       dvs_ext;
   logic [PW-1:0]                       diff;
   logic                                ge;

   always_comb begin
      dvs_ext = {1'b0, in_dvs};
      diff    = '0;
      ge      = 1'b0;
      for (int l = 0; l < rmq_pkg::LANES; l++) begin
         ps[l]   = {in_p[l], in_n[l][NW-1]};
         ge      = (ps[l] >= dvs_ext);
         diff    = ps[l] - dvs_ext;
         p_in[l] = ge ? diff[DVW-1:0] : ps[l][DVW-1:0];
         q_in[l] = {in_q[l][NW-2:0], ge};
         n_in[l] = {in_n[l][NW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff  <= in_ctl;
         dvs_ff  <= in_dvs;
         lead_ff <= in_lead;
         n_ff    <= n_in;
         p_ff    <= p_in;
         q_ff    <= q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_dvs   = dvs_ff;
   assign out_lead  = lead_ff;
   assign out_n     = n_ff;
   assign out_p     = p_ff;
   assign out_q     = q_ff;

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion_core.sv =====
// Converts a 3x3 rotation matrix in signed fixed point (Q2.14 by default) to a
// quaternion in the same format, one transaction per clock cycle sustained
// while rsp_ready stays high. The datapath is a fully pipelined chain: one
// input stage, one square-root cell per root bit ((ELEM_WIDTH+FRAC_BITS+3)/2
// cells), one rounding stage, one division cell per quotient bit
// (ELEM_WIDTH+FRAC_BITS+2 cells, three lanes each) and the output register.
// The whole pipeline advances when the output register is empty or being
// taken, so req_ready falls only while a finished result waits. A radicand
// that is not positive returns zeros with rsp_degenerate set;
// rsp_branch_taken always names the branch chosen.
module rotation_matrix_to_quaternion_core #(
   parameter int FRAC_BITS  = 14,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ELEM_WIDTH-1:0] req_a00,
   input  logic signed [ELEM_WIDTH-1:0] req_a01,
   input  logic signed [ELEM_WIDTH-1:0] req_a02,
   input  logic signed [ELEM_WIDTH-1:0] req_a10,
   input  logic signed [ELEM_WIDTH-1:0] req_a11,
   input  logic signed [ELEM_WIDTH-1:0] req_a12,
   input  logic signed [ELEM_WIDTH-1:0] req_a20,
   input  logic signed [ELEM_WIDTH-1:0] req_a21,
   input  logic signed [ELEM_WIDTH-1:0] req_a22,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ELEM_WIDTH-1:0] rsp_quat_x,
   output logic signed [ELEM_WIDTH-1:0] rsp_quat_y,
   output logic signed [ELEM_WIDTH-1:0] rsp_quat_z,
   output logic signed [ELEM_WIDTH-1:0] rsp_quat_w,
   output logic [1:0]                   rsp_branch_taken,
   output logic                         rsp_degenerate
);
   localparam int W    = ELEM_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int L    = rmq_pkg::LANES;
   localparam int XW   = W + 3;
   localparam int MW   = W + 1;
   localparam int SQW  = (W + F + 3) / 2;
   localparam int VW   = 2 * SQW;
   localparam int RMW  = SQW + 3;
   localparam int RTW  = SQW + 1;
   localparam int DVW  = SQW + 2;
   localparam int NW   = MW + F + 1;
   localparam logic signed [XW-1:0] ONE     = XW'(1) << F;
   localparam logic [NW-1:0]        POS_LIM = (NW'(1) << (W - 1)) - NW'(1);
   localparam logic [NW-1:0]        NEG_LIM = NW'(1) << (W - 1);

   logic adv;

   // Input stage.
   logic signed [XW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [XW-1:0] tr, rad;
   logic signed [L-1:0][XW-1:0] lane;
   logic [L-1:0][MW-1:0] mag_in;
   logic [XW-1:0]        neg_val;
   rmq_pkg::ctl_type     ctl_in;
   logic [VW-1:0]        v_in;

   logic                 s0_valid_ff;
   rmq_pkg::ctl_type     s0_ctl_ff;
   logic [VW-1:0]        s0_v_ff;
   logic [L-1:0][MW-1:0] s0_mag_ff;

   always_comb begin
      e00 = {{3{req_a00[W-1]}}, req_a00};
      e01 = {{3{req_a01[W-1]}}, req_a01};
      e02 = {{3{req_a02[W-1]}}, req_a02};
      e10 = {{3{req_a10[W-1]}}, req_a10};
      e11 = {{3{req_a11[W-1]}}, req_a11};
      e12 = {{3{req_a12[W-1]}}, req_a12};
      e20 = {{3{req_a20[W-1]}}, req_a20};
      e21 = {{3{req_a21[W-1]}}, req_a21};
      e22 = {{3{req_a22[W-1]}}, req_a22};
      tr  = e00 + e11 + e22;
      if (tr > 0) begin
         ctl_in.branch = rmq_pkg::BR_TRACE;
      end else if (e00 > e11 && e00 > e22) begin
         ctl_in.branch = rmq_pkg::BR_X;
      end else if (e11 > e22) begin
         ctl_in.branch = rmq_pkg::BR_Y;
      end else begin
         ctl_in.branch = rmq_pkg::BR_Z;
      end
      // Lanes hold the three non-leading components in x, y, z, w order.
      case (ctl_in.branch)
         rmq_pkg::BR_TRACE: begin
            rad     = ONE + tr;
            lane[0] = e12 - e21;
            lane[1] = e20 - e02;
            lane[2] = e01 - e10;
         end
         rmq_pkg::BR_X: begin
            rad     = ONE + e00 - e11 - e22;
            lane[0] = e01 + e10;
            lane[1] = e02 + e20;
            lane[2] = e12 - e21;
         end
         rmq_pkg::BR_Y: begin
            rad     = ONE - e00 + e11 - e22;
            lane[0] = e01 + e10;
            lane[1] = e12 + e21;
            lane[2] = e20 - e02;
         end
         default: begin
            rad     = ONE - e00 - e11 + e22;
            lane[0] = e02 + e20;
            lane[1] = e12 + e21;
            lane[2] = e01 - e10;
         end
      endcase
      ctl_in.degen = (rad <= 0);
      for (int l = 0; l < L; l++) begin
         ctl_in.neg[l] = lane[l][XW-1];
         neg_val       = -lane[l];
         mag_in[l]     = ctl_in.neg[l] ? neg_val[MW-1:0] : lane[l][MW-1:0];
      end
      v_in = ctl_in.degen ? '0 : VW'({rad[XW-2:0], {F{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ctl_ff <= ctl_in;
         s0_v_ff   <= v_in;
         s0_mag_ff <= mag_in;
      end
   end

   // Square-root chain.
   logic                 sq_valid [0:SQW];
   rmq_pkg::ctl_type     sq_ctl   [0:SQW];
   logic [VW-1:0]        sq_v     [0:SQW];
   logic [SQW-1:0]       sq_q     [0:SQW];
   logic [RMW-1:0]       sq_r     [0:SQW];
   logic [L*MW-1:0]      sq_data  [0:SQW];

   assign sq_valid[0] = s0_valid_ff;
   assign sq_ctl[0]   = s0_ctl_ff;
   assign sq_v[0]     = s0_v_ff;
   assign sq_q[0]     = '0;
   assign sq_r[0]     = '0;
   assign sq_data[0]  = s0_mag_ff;

   for (genvar k = 0; k < SQW; k++) begin : g_sqrt
      rmq_sqrt_cell #(.SQW(SQW), .DW(L * MW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_valid[k]),
         .in_ctl    (sq_ctl[k]),
         .in_v      (sq_v[k]),
         .in_q      (sq_q[k]),
         .in_r      (sq_r[k]),
         .in_data   (sq_data[k]),
         .out_valid (sq_valid[k+1]),
         .out_ctl   (sq_ctl[k+1]),
         .out_v     (sq_v[k+1]),
         .out_q     (sq_q[k+1]),
         .out_r     (sq_r[k+1]),
         .out_data  (sq_data[k+1])
      );
   end

   // Rounding stage: root to nearest, divisor and numerators.
   logic [L-1:0][MW-1:0] sq_mag;
   logic [RTW-1:0]       root;
   logic [RTW:0]         lead_sum;
   logic [L-1:0][NW-1:0] num_in;

   logic                 rt_valid_ff;
   rmq_pkg::ctl_type     rt_ctl_ff;
   logic [RTW-1:0]       rt_lead_ff;
   logic [DVW-1:0]       rt_dvs_ff;
   logic [L-1:0][NW-1:0] rt_n_ff;

   always_comb begin
      sq_mag   = sq_data[SQW];
      root     = {1'b0, sq_q[SQW]} + RTW'(sq_r[SQW] > {3'b000, sq_q[SQW]});
      lead_sum = {1'b0, root} + (RTW + 1)'(1);
      for (int l = 0; l < L; l++) begin
         num_in[l] = NW'({sq_mag[l], {F{1'b0}}}) + NW'(root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_valid_ff <= 1'b0;
      end else if (adv) begin
         rt_valid_ff <= sq_valid[SQW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_ctl_ff  <= sq_ctl[SQW];
         rt_lead_ff <= lead_sum[RTW:1];
         rt_dvs_ff  <= {root, 1'b0};
         rt_n_ff    <= num_in;
      end
   end

   // Division chain.
   logic                  dv_valid [0:NW];
   rmq_pkg::ctl_type      dv_ctl   [0:NW];
   logic [DVW-1:0]        dv_dvs   [0:NW];
   logic [RTW-1:0]        dv_lead  [0:NW];
   logic [L-1:0][NW-1:0]  dv_n     [0:NW];
   logic [L-1:0][DVW-1:0] dv_p     [0:NW];
   logic [L-1:0][NW-1:0]  dv_q     [0:NW];

   assign dv_valid[0] = rt_valid_ff;
   assign dv_ctl[0]   = rt_ctl_ff;
   assign dv_dvs[0]   = rt_dvs_ff;
   assign dv_lead[0]  = rt_lead_ff;
   assign dv_n[0]     = rt_n_ff;
   assign dv_p[0]     = '0;
   assign dv_q[0]     = '0;

   for (genvar k = 0; k < NW; k++) begin : g_div
      rmq_div_cell #(.NW(NW), .DVW(DVW), .LW(RTW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_valid[k]),
         .in_ctl    (dv_ctl[k]),
         .in_dvs    (dv_dvs[k]),
         .in_lead   (dv_lead[k]),
         .in_n      (dv_n[k]),
         .in_p      (dv_p[k]),
         .in_q      (dv_q[k]),
         .out_valid (dv_valid[k+1]),
         .out_ctl   (dv_ctl[k+1]),
         .out_dvs   (dv_dvs[k+1]),
         .out_lead  (dv_lead[k+1]),
         .out_n     (dv_n[k+1]),
         .out_p     (dv_p[k+1]),
         .out_q     (dv_q[k+1])
      );
   end

   // Output stage: sign, saturation and placement of the components.
   rmq_pkg::ctl_type     fin_ctl;
   logic [L-1:0][NW-1:0] fin_q;
   logic [L-1:0][W-1:0]  comp;
   logic [NW-1:0]        neg_q;
   logic [NW-1:0]        lead_ext;
   logic [W-1:0]         lead_sat;
   logic [W-1:0]         x_in, y_in, z_in, w_in;

   always_comb begin
      fin_ctl  = dv_ctl[NW];
      fin_q    = dv_q[NW];
      lead_ext = NW'(dv_lead[NW]);
      lead_sat = (lead_ext > POS_LIM) ? POS_LIM[W-1:0] : lead_ext[W-1:0];
      for (int l = 0; l < L; l++) begin
         neg_q = -fin_q[l];
         if (fin_ctl.neg[l]) begin
            comp[l] = (fin_q[l] > NEG_LIM) ? NEG_LIM[W-1:0] : neg_q[W-1:0];
         end else begin
            comp[l] = (fin_q[l] > POS_LIM) ? POS_LIM[W-1:0] : fin_q[l][W-1:0];
         end
      end
      case (fin_ctl.branch)
         rmq_pkg::BR_TRACE: begin
            x_in = comp[0]; y_in = comp[1]; z_in = comp[2]; w_in = lead_sat;
         end
         rmq_pkg::BR_X: begin
            x_in = lead_sat; y_in = comp[0]; z_in = comp[1]; w_in = comp[2];
         end
         rmq_pkg::BR_Y: begin
            x_in = comp[0]; y_in = lead_sat; z_in = comp[1]; w_in = comp[2];
         end
         default: begin
            x_in = comp[0]; y_in = comp[1]; z_in = lead_sat; w_in = comp[2];
         end
      endcase
      if (fin_ctl.degen) begin
         x_in = '0; y_in = '0; z_in = '0; w_in = '0;
      end
   end

   logic         rsp_valid_ff;
   logic [W-1:0] x_ff, y_ff, z_ff, w_ff;
   logic [1:0]   branch_ff;
   logic         degen_ff;

   // Everything moves together unless a finished result is held at the output.
   assign adv = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff      <= x_in;
         y_ff      <= y_in;
         z_ff      <= z_in;
         w_ff      <= w_in;
         branch_ff <= fin_ctl.branch;
         degen_ff  <= fin_ctl.degen;
      end
   end

   assign req_ready        = adv;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_quat_x       = x_ff;
   assign rsp_quat_y       = y_ff;
   assign rsp_quat_z       = z_ff;
   assign rsp_quat_w       = w_ff;
   assign rsp_branch_taken = branch_ff;
   assign rsp_degenerate   = degen_ff;

endmodule

// ===== hw/rtl/rmq_checker.sv =====
`include "assert_macros.svh"

module rmq_checker #(
   parameter int ELEM_WIDTH = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [ELEM_WIDTH-1:0] rsp_quat_x,
   input logic [ELEM_WIDTH-1:0] rsp_quat_y,
   input logic [ELEM_WIDTH-1:0] rsp_quat_z,
   input logic [ELEM_WIDTH-1:0] rsp_quat_w,
   input logic [1:0]            rsp_branch_taken,
   input logic                  rsp_degenerate
);

   // A held result blocks new transactions.
   `RMQ_ASSERT(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready |-> !req_ready)

   // A degenerate transaction carries an all-zero quaternion.
   `RMQ_ASSERT(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate |-> rsp_quat_x == 0 && rsp_quat_y == 0 && rsp_quat_z == 0 && rsp_quat_w == 0)

   // The pipeline is empty right after reset.
   `RMQ_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   `RMQ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   `RMQ_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_quat_x) && $stable(rsp_quat_w) && $stable(rsp_branch_taken))

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_rmq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_quat_x       (rsp_quat_x),
   .rsp_quat_y       (rsp_quat_y),
   .rsp_quat_z       (rsp_quat_z),
   .rsp_quat_w       (rsp_quat_w),
   .rsp_branch_taken (rsp_branch_taken),
   .rsp_degenerate   (rsp_degenerate)
);
